### sv/intake_sort_unjam_sequencer_macros.svh
// assertion macros used by the sequencer module
`ifndef INTAKE_SORT_UNJAM_SEQUENCER_MACROS_SVH
`define INTAKE_SORT_UNJAM_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ISUS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// next-cycle implication, checked outside reset
`define ISUS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

### sv/isus_pkg.sv
package isus_pkg;

    // countdown width
    localparam int COUNT_WIDTH = 16;
    // configuration register width
    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0] cfg_word_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_INTAKE = 3'd1,
        MODE_BOTH   = 3'd2,
        MODE_OUT    = 3'd3,
        MODE_QUEUE  = 3'd4,
        MODE_THROW  = 3'd5,
        MODE_UNREV  = 3'd6,
        MODE_UNFWD  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ICMD_NONE = 2'd0,
        ICMD_FWD  = 2'd1,
        ICMD_REV  = 2'd2,
        ICMD_STOP = 2'd3
    } icmd_t;

    typedef enum logic [2:0] {
        CCMD_NONE  = 3'd0,
        CCMD_FWD   = 3'd1,
        CCMD_REV   = 3'd2,
        CCMD_STOP  = 3'd3,
        CCMD_THROW = 3'd4
    } ccmd_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SORT_ENABLED  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JAM_RECOVERY  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUEUE_DELAY   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THROW_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNJAM_REVERSE = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNJAM_FORWARD = 3'd5;

    // reset value of every tick register
    localparam cfg_word_t TICKS_RESET = 16'd10;

    typedef struct packed {
        logic intake_button;
        logic both_button;
        logic reverse_button;
        logic opposite_ring;
        logic conveyor_jammed;
    } isus_in_t;

    typedef struct packed {
        mode_t mode;
        icmd_t intake_cmd;
        ccmd_t conveyor_cmd;
    } isus_out_t;

    typedef struct packed {
        logic      sort_enabled;
        logic      jam_recovery_enable;
        cfg_word_t queue_delay_ticks;
        cfg_word_t throw_ticks;
        cfg_word_t unjam_reverse_ticks;
        cfg_word_t unjam_forward_ticks;
    } isus_cfg_t;

    // fit a tick register value into the countdown width
    function automatic count_t fit_count(input cfg_word_t value);
        logic [COUNT_WIDTH+CFG_WIDTH-1:0] wide;
        wide = {{COUNT_WIDTH{1'b0}}, value};
        return wide[COUNT_WIDTH-1:0];
    endfunction

endpackage

### sv/intake_sort_unjam_sequencer.sv
// channel  | direction | handshake         | payload
// in       | input     | in_valid/in_stall | in_data   (buttons, color flag, jam flag)
// out      | output    | out_valid/out_stall | out_data (mode, intake and conveyor cmd)
// cfg      | input     | cfg_wr_en         | cfg_index, cfg_data
//
// the step logic sits between the mode/count registers and the result register,
// so a transaction can be accepted every cycle while in_stall is low
// one result per transaction, visible the cycle after acceptance
// in_stall rises only while a result is held and out_stall is high
// reset clears mode and countdown and loads the register defaults
module intake_sort_unjam_sequencer
    import isus_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  isus_in_t                   in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output isus_out_t                  out_data,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  cfg_word_t                  cfg_data
);

`include "intake_sort_unjam_sequencer_macros.svh"

    isus_cfg_t cfg_reg;
    isus_cfg_t cfg_next;
    mode_t     mode_reg;
    mode_t     mode_next;
    count_t    count_reg;
    count_t    count_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    isus_out_t out_data_reg;
    isus_out_t step_result;
    logic      in_accept;

    // accept while the result slot is empty or being drained
    assign in_stall = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SORT_ENABLED:  cfg_next.sort_enabled = cfg_data[0];
                CFG_JAM_RECOVERY:  cfg_next.jam_recovery_enable = cfg_data[0];
                CFG_QUEUE_DELAY:   cfg_next.queue_delay_ticks = cfg_data;
                CFG_THROW_TICKS:   cfg_next.throw_ticks = cfg_data;
                CFG_UNJAM_REVERSE: cfg_next.unjam_reverse_ticks = cfg_data;
                CFG_UNJAM_FORWARD: cfg_next.unjam_forward_ticks = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sort_enabled <= 1'b1;
            cfg_reg.jam_recovery_enable <= 1'b1;
            cfg_reg.queue_delay_ticks <= TICKS_RESET;
            cfg_reg.throw_ticks <= TICKS_RESET;
            cfg_reg.unjam_reverse_ticks <= TICKS_RESET;
            cfg_reg.unjam_forward_ticks <= TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // transition logic
    isus_step u_step (
        .mode_cur  (mode_reg),
        .count_cur (count_reg),
        .item      (in_data),
        .cfg       (cfg_reg),
        .mode_new  (mode_next),
        .count_new (count_next),
        .result    (step_result)
    );

    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                mode_reg <= mode_next;
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // checks
    `ISUS_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
    `ISUS_ASSERT_NOW(a_result_mode_matches, out_valid, out_data.mode == mode_reg)
    `ISUS_ASSERT_NOW(a_untimed_modes_no_count,
        (mode_reg == MODE_IDLE) || (mode_reg == MODE_INTAKE) || (mode_reg == MODE_BOTH)
        || (mode_reg == MODE_OUT), count_reg == '0)
    `ISUS_ASSERT_NEXT(a_state_holds_without_accept, !in_accept,
        $stable(mode_reg) && $stable(count_reg))

endmodule

### sv/isus_step.sv
module isus_step
    import isus_pkg::*;
(
    input  mode_t     mode_cur,
    input  count_t    count_cur,
    input  isus_in_t  item,
    input  isus_cfg_t cfg,
    output mode_t     mode_new,
    output count_t    count_new,
    output isus_out_t result
);

    logic   sel_valid;
    mode_t  sel_mode;
    icmd_t  sel_icmd;
    ccmd_t  sel_ccmd;
    logic   expired;
    count_t count_dec;
    logic   ib;
    logic   bb;
    logic   rb;
    logic   sort_req;
    logic   jam_req;

    assign ib = item.intake_button;
    assign bb = item.both_button;
    assign rb = item.reverse_button;
    assign sort_req = item.opposite_ring & cfg.sort_enabled;
    assign jam_req = item.conveyor_jammed & cfg.jam_recovery_enable;

    // countdown step
    assign expired = (count_cur <= count_t'(1));
    assign count_dec = expired ? '0 : count_cur - count_t'(1);

    // single-button mode choice, idle when none or several are pressed
    always_comb
    begin
        sel_valid = 1'b1;
        sel_mode = MODE_IDLE;
        sel_icmd = ICMD_STOP;
        sel_ccmd = CCMD_STOP;
        if (ib && !bb && !rb)
        begin
            sel_mode = MODE_INTAKE;
            sel_icmd = ICMD_FWD;
            sel_ccmd = CCMD_NONE;
        end
        else if (bb && !ib && !rb)
        begin
            sel_mode = MODE_BOTH;
            sel_icmd = ICMD_FWD;
            sel_ccmd = CCMD_FWD;
        end
        else if (rb && !ib && !bb)
        begin
            sel_mode = MODE_OUT;
            sel_icmd = ICMD_REV;
            sel_ccmd = CCMD_REV;
        end
        else
        begin
            sel_valid = 1'b0;
        end
    end

    // mode transitions
    always_comb
    begin
        mode_new = mode_cur;
        count_new = count_cur;
        result.intake_cmd = ICMD_NONE;
        result.conveyor_cmd = CCMD_NONE;
        case (mode_cur)
            MODE_IDLE:
            begin
                if (sel_valid)
                begin
                    mode_new = sel_mode;
                    result.intake_cmd = sel_icmd;
                    result.conveyor_cmd = sel_ccmd;
                end
            end
            MODE_INTAKE, MODE_BOTH:
            begin
                if (((mode_cur == MODE_INTAKE) && !ib && !bb)
                    || ((mode_cur == MODE_BOTH) && !bb) || rb)
                begin
                    mode_new = MODE_IDLE;
                    result.intake_cmd = ICMD_STOP;
                    result.conveyor_cmd = CCMD_STOP;
                end
                else if ((mode_cur == MODE_INTAKE) && bb)
                begin
                    mode_new = MODE_BOTH;
                    result.intake_cmd = ICMD_FWD;
                    result.conveyor_cmd = CCMD_FWD;
                end
                else if (sort_req)
                begin
                    mode_new = MODE_QUEUE;
                    count_new = fit_count(cfg.queue_delay_ticks);
                end
                else if (jam_req)
                begin
                    mode_new = MODE_UNREV;
                    count_new = fit_count(cfg.unjam_reverse_ticks);
                    result.intake_cmd = ICMD_REV;
                    result.conveyor_cmd = CCMD_REV;
                end
            end
            MODE_OUT:
            begin
                if (!rb || ib || bb)
                begin
                    mode_new = MODE_IDLE;
                    result.intake_cmd = ICMD_STOP;
                    result.conveyor_cmd = CCMD_STOP;
                end
            end
            MODE_QUEUE:
            begin
                count_new = count_dec;
                if (expired && cfg.sort_enabled)
                begin
                    mode_new = MODE_THROW;
                    count_new = fit_count(cfg.throw_ticks);
                    result.intake_cmd = ICMD_STOP;
                    result.conveyor_cmd = CCMD_THROW;
                end
                else if ((!ib && !bb) || rb || !cfg.sort_enabled)
                begin
                    mode_new = MODE_IDLE;
                    count_new = '0;
                    result.intake_cmd = ICMD_STOP;
                    result.conveyor_cmd = CCMD_STOP;
                end
            end
            MODE_THROW, MODE_UNFWD:
            begin
                count_new = count_dec;
                if (expired || ((mode_cur == MODE_THROW) && !cfg.sort_enabled))
                begin
                    mode_new = sel_mode;
                    count_new = '0;
                    result.intake_cmd = sel_icmd;
                    result.conveyor_cmd = sel_ccmd;
                end
            end
            MODE_UNREV:
            begin
                count_new = count_dec;
                if (expired)
                begin
                    mode_new = MODE_UNFWD;
                    count_new = fit_count(cfg.unjam_forward_ticks);
                    result.intake_cmd = ICMD_FWD;
                    result.conveyor_cmd = CCMD_FWD;
                end
            end
            default:
            begin
                mode_new = MODE_IDLE;
            end
        endcase
        result.mode = mode_new;
    end

endmodule
